FILE: hdl/asc_pkg.sv
// package with shared types, widths and codes of the adc spike canceller
`timescale 1ns / 1ps

package asc_pkg;

  // default geometry of the block
  localparam int NUM_PADS_DEF       = 8;
  localparam int INPUTS_PER_PAD_DEF = 4;
  localparam int SAMPLE_BITS_DEF    = 13;

  // fixed field widths
  localparam int PAD_W   = 3;
  localparam int PIN_W   = 2;
  localparam int THR_W   = 12;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  // threshold reset values
  localparam logic [THR_W-1:0] NOISE_THR_RST = 12'd8;
  localparam logic [THR_W-1:0] SPIKE_THR_RST = 12'd150;

  // register index, taken from paddr bit 2
  localparam logic REG_NOISE_THR = 1'b0;
  localparam logic REG_SPIKE_THR = 1'b1;

  // sample classes
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_OTHER = 2'd0;
  localparam cls_t CLS_NOISE = 2'd1;
  localparam cls_t CLS_SPIKE = 2'd2;

endpackage

FILE: hdl/asc_in_if.sv
// input request channel carrying one sample and its channel address
`timescale 1ns / 1ps

interface asc_in_if #(
  parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
);
  import asc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [PAD_W-1:0]              pad;
  logic [PIN_W-1:0]              pad_input;

  modport source (output valid, output sample, output pad, output pad_input, input ready);
  modport sink   (input valid, input sample, input pad, input pad_input, output ready);
endinterface

FILE: hdl/asc_out_if.sv
// result request channel carrying one cleaned sample
`timescale 1ns / 1ps

interface asc_out_if #(
  parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] cleaned_sample;

  modport source (output valid, output cleaned_sample, input ready);
  modport sink   (input valid, input cleaned_sample, output ready);
endinterface

FILE: hdl/adc_spike_canceller_core.sv
// top level of the adc spike canceller: history memory, update pipeline and apb registers
`timescale 1ns / 1ps

// Removes one- and two-sample spikes from multiplexed ADC streams. Every channel (one input
// of one pad) has an entry in a history memory holding the classes of its last three samples
// and its last two raw samples; each request returns that channel's sample from two requests
// earlier, zeroed where the class pattern marks a spike. One request is taken every clock
// cycle unless the output stalls; its result passes the stage one and output registers:
// the history memory is read in the acceptance cycle, and the entry is updated and written
// back when stage one advances, with the last write forwarded when two requests to the
// same channel follow each other. A request whose pad or input number lies outside the
// configured geometry returns zero and leaves all history unchanged. Histories start as
// "all other, samples zero" after reset with no clearing pass. Thresholds are at 0x0 (noise)
// and 0x4 (spike) and should only be written while no request is in flight.

module adc_spike_canceller_core #(
  parameter int NUM_PADS       = asc_pkg::NUM_PADS_DEF,
  parameter int INPUTS_PER_PAD = asc_pkg::INPUTS_PER_PAD_DEF,
  parameter int SAMPLE_BITS    = asc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  asc_in_if.sink                         in_chan,
  asc_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [asc_pkg::PADDR_W-1:0]    paddr,
  input  logic [asc_pkg::APB_W-1:0]      pwdata,
  output logic [asc_pkg::APB_W-1:0]      prdata,
  output logic                           pready
);
  import asc_pkg::*;

  localparam int NUM_CH = NUM_PADS * INPUTS_PER_PAD;
  localparam int CH_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // one history entry: c0 newest class, smp0 previous sample
  typedef struct packed {
    cls_t c2;
    cls_t c1;
    cls_t c0;
    smp_t smp1;
    smp_t smp0;
  } hist_t;

  // configuration registers
  logic [THR_W-1:0] noise_thr_r;
  logic [THR_W-1:0] spike_thr_r;
  logic             cfg_wr;

  // history memory and per-entry valid bits
  hist_t             hist_mem [NUM_CH];
  logic [NUM_CH-1:0] ent_vld_r;

  // stage one registers
  logic            s1_vld_r;
  logic            s1_inr_r;
  logic [CH_W-1:0] s1_ch_r;
  smp_t            s1_smp_r;
  cls_t            s1_cls_r;
  hist_t           rd_data_r;
  logic            rd_vld_r;

  // last write-back, for forwarding
  logic            wb_vld_r;
  logic [CH_W-1:0] wb_ch_r;
  hist_t           wb_data_r;

  // output register
  logic out_vld_r;
  smp_t out_smp_r;

  // stage zero signals
  logic                   accept;
  logic                   advance;
  logic                   in_range;
  logic [CH_W-1:0]        in_ch;
  logic [SAMPLE_BITS-1:0] mag;
  logic [CMP_W-1:0]       mag_ext;
  cls_t                   in_cls;

  // stage one signals
  hist_t cur;
  hist_t upd;
  smp_t  result;
  logic  pat_nsn;
  logic  pat_kill;
  logic  wr_en;

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_thr_r <= NOISE_THR_RST;
      spike_thr_r <= SPIKE_THR_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NOISE_THR) begin
        noise_thr_r <= pwdata[THR_W-1:0];
      end else begin
        spike_thr_r <= pwdata[THR_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SPIKE_THR) begin
      prdata = APB_W'(spike_thr_r);
    end else begin
      prdata = APB_W'(noise_thr_r);
    end
  end

  // handshake: stage one moves on whenever the output register is free or being taken
  assign advance       = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !s1_vld_r || advance;
  assign accept        = in_chan.valid && in_chan.ready;

  // channel decode
  always_comb begin
    in_range = (32'(in_chan.pad) < NUM_PADS) && (32'(in_chan.pad_input) < INPUTS_PER_PAD);
    in_ch    = '0;
    if (in_range) begin
      in_ch = CH_W'(32'(in_chan.pad) * INPUTS_PER_PAD + 32'(in_chan.pad_input));
    end
  end

  // magnitude and class of the incoming sample
  always_comb begin
    if (in_chan.sample[SAMPLE_BITS-1]) begin
      mag = unsigned'(-in_chan.sample);
    end else begin
      mag = unsigned'(in_chan.sample);
    end
    mag_ext = CMP_W'(mag);
    if (mag_ext < CMP_W'(noise_thr_r)) begin
      in_cls = CLS_NOISE;
    end else if (mag_ext < CMP_W'(spike_thr_r)) begin
      in_cls = CLS_SPIKE;
    end else begin
      in_cls = CLS_OTHER;
    end
  end

  // stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  // stage one payload and memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_inr_r  <= in_range;
      s1_ch_r   <= in_ch;
      s1_smp_r  <= in_chan.sample;
      s1_cls_r  <= in_cls;
      rd_data_r <= hist_mem[in_ch];
      rd_vld_r  <= ent_vld_r[in_ch];
    end
  end

  // entry as seen by stage one, with the newest write forwarded
  always_comb begin
    if (wb_vld_r && (wb_ch_r == s1_ch_r)) begin
      cur = wb_data_r;
    end else if (rd_vld_r) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end
  end

  // spike patterns and history update
  always_comb begin
    pat_nsn  = (cur.c2 == CLS_NOISE) && (cur.c1 == CLS_SPIKE) && (cur.c0 == CLS_NOISE);
    pat_kill = (cur.c2 == CLS_NOISE) && (cur.c1 == CLS_SPIKE) && (cur.c0 == CLS_SPIKE)
               && (s1_cls_r == CLS_NOISE);
    result = cur.smp1;
    if (pat_nsn || pat_kill || !s1_inr_r) begin
      result = '0;
    end
    upd.c2   = cur.c1;
    upd.c1   = cur.c0;
    upd.c0   = s1_cls_r;
    upd.smp1 = pat_kill ? '0 : cur.smp0;
    upd.smp0 = s1_smp_r;
  end

  assign wr_en = advance && s1_vld_r && s1_inr_r;

  // memory write-back
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[s1_ch_r] <= upd;
    end
  end

  // valid bits and forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      wb_vld_r  <= 1'b0;
    end else if (wr_en) begin
      ent_vld_r[s1_ch_r] <= 1'b1;
      wb_vld_r           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_ch_r   <= s1_ch_r;
      wb_data_r <= upd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_vld_r) begin
      out_smp_r <= result;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.cleaned_sample = out_smp_r;

endmodule
